// File: sv/sv39_ptw_pkg.sv
// Shared types and constants for the Sv39 page table walker.
package sv39_ptw_pkg;

	localparam int unsigned WALK_LEVELS = 3;
	localparam int unsigned PPN_W       = 44;
	localparam int unsigned VPN_W       = 9;
	localparam int unsigned PAGE_OFS_W  = 12;

	localparam logic FUNC_TRANSLATE = 1'b0;
	localparam logic FUNC_RESPONSE  = 1'b1;

	localparam logic [1:0] ACC_FETCH = 2'd0;
	localparam logic [1:0] ACC_LOAD  = 2'd1;
	localparam logic [1:0] ACC_STORE = 2'd2;

	localparam logic [1:0] PRIV_U_MODE = 2'd0;
	localparam logic [1:0] PRIV_M_MODE = 2'd3;

	localparam logic [1:0] RES_DONE  = 2'd0;
	localparam logic [1:0] RES_FAULT = 2'd1;
	localparam logic [1:0] RES_READ  = 2'd2;
	localparam logic [1:0] RES_WRITE = 2'd3;

	localparam logic [1:0] CAUSE_FETCH = 2'd0;
	localparam logic [1:0] CAUSE_LOAD  = 2'd1;
	localparam logic [1:0] CAUSE_STORE = 2'd2;

	localparam logic [1:0] CFG_MODE = 2'd0;
	localparam logic [1:0] CFG_ROOT = 2'd1;
	localparam logic [1:0] CFG_SUM  = 2'd2;
	localparam logic [1:0] CFG_MXR  = 2'd3;

	localparam logic [3:0] MODE_BARE = 4'd0;

	localparam int unsigned PTE_V = 0;
	localparam int unsigned PTE_R = 1;
	localparam int unsigned PTE_W = 2;
	localparam int unsigned PTE_X = 3;
	localparam int unsigned PTE_U = 4;
	localparam int unsigned PTE_A = 6;
	localparam int unsigned PTE_D = 7;

	localparam logic [1:0] TOP_LEVEL = 2'(WALK_LEVELS - 1);

	typedef struct packed {
		logic        func;
		logic [63:0] virt_addr;
		logic [1:0]  access_kind;
		logic [1:0]  privilege;
		logic [63:0] read_data;
		logic        read_error;
	} req_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [63:0] address;
		logic [63:0] write_data;
		logic [1:0]  fault_cause;
		logic        last_of_run;
	} rsp_t;

	typedef struct packed {
		logic [3:0]       mode;
		logic [PPN_W-1:0] root_ppn;
		logic             sum;
		logic             mxr;
	} cfg_t;

	typedef struct packed {
		logic             busy;
		logic [1:0]       level;
		logic [PPN_W-1:0] table_ppn;
		logic [63:0]      vaddr;
		logic [1:0]       kind;
		logic [1:0]       priv;
	} walk_state_t;

endpackage

// File: sv/sv39_ptw_step.sv
// Combinational handling of one request against the walk state and configuration.
module sv39_ptw_step (
	input  sv39_ptw_pkg::req_t        req,
	input  sv39_ptw_pkg::walk_state_t state,
	input  sv39_ptw_pkg::cfg_t        cfg,
	output logic [1:0]                res_n,
	output sv39_ptw_pkg::rsp_t        res0,
	output sv39_ptw_pkg::rsp_t        res1,
	output sv39_ptw_pkg::walk_state_t state_next
);
	import sv39_ptw_pkg::*;

	function automatic logic [63:0] pte_addr(logic [PPN_W-1:0] ppn, logic [63:0] va,
			logic [1:0] lvl);
		logic [VPN_W-1:0] idx;
		case (lvl)
			2'd0: idx = va[20:12];
			2'd1: idx = va[29:21];
			2'd2: idx = va[38:30];
			default: idx = '0;
		endcase
		return {8'd0, ppn, idx, 3'd0};
	endfunction

	function automatic logic [1:0] cause_of(logic [1:0] kind);
		if (kind == ACC_FETCH)
			return CAUSE_FETCH;
		if (kind == ACC_STORE)
			return CAUSE_STORE;
		return CAUSE_LOAD;
	endfunction

	function automatic rsp_t make_rsp(logic [1:0] kind, logic [63:0] addr,
			logic [63:0] wdata, logic [1:0] cause, logic last);
		rsp_t r;
		r.result_kind = kind;
		r.address     = addr;
		r.write_data  = wdata;
		r.fault_cause = cause;
		r.last_of_run = last;
		return r;
	endfunction

	logic [25:0]      va_high;
	logic [63:0]      pte;
	logic [PPN_W-1:0] pte_ppn;
	logic [PPN_W-1:0] low_mask;
	logic [PPN_W-1:0] leaf_ppn;
	logic [4:0]       shamt;
	logic             pte_user;
	logic             priv_ok;
	logic             kind_ok;
	logic [63:0]      updated;
	logic [63:0]      phys_addr;
	rsp_t             fault_rsp;

	assign va_high   = req.virt_addr[63:38];
	assign pte       = req.read_data;
	assign pte_ppn   = pte[53:10];
	assign shamt     = 5'(state.level) * 5'd9;
	assign low_mask  = (PPN_W'(1) << shamt) - PPN_W'(1);
	assign leaf_ppn  = pte_ppn | (state.vaddr[55:12] & low_mask);
	assign phys_addr = {8'd0, leaf_ppn, state.vaddr[11:0]};
	assign pte_user  = pte[PTE_U];
	assign fault_rsp = make_rsp(RES_FAULT, state.vaddr, 64'd0, cause_of(state.kind), 1'b1);

	always_comb begin
		if (state.priv == PRIV_U_MODE)
			priv_ok = pte_user;
		else
			priv_ok = !(pte_user && (state.kind == ACC_FETCH || !cfg.sum));
		case (state.kind)
			ACC_FETCH: kind_ok = pte[PTE_X];
			ACC_LOAD:  kind_ok = pte[PTE_R] || (cfg.mxr && pte[PTE_X]);
			ACC_STORE: kind_ok = pte[PTE_W];
			default:   kind_ok = 1'b0;
		endcase
		updated = pte;
		updated[PTE_A] = 1'b1;
		if (state.kind == ACC_STORE)
			updated[PTE_D] = 1'b1;
	end

	always_comb begin
		state_next = state;
		res_n      = 2'd0;
		res0       = '0;
		res1       = '0;
		if (req.func == FUNC_TRANSLATE) begin
			if (!state.busy) begin
				res_n = 2'd1;
				if (req.privilege == PRIV_M_MODE || cfg.mode == MODE_BARE) begin
					res0 = make_rsp(RES_DONE, req.virt_addr, 64'd0, CAUSE_FETCH, 1'b1);
				end else if (va_high != '0 && va_high != '1) begin
					res0 = make_rsp(RES_FAULT, req.virt_addr, 64'd0,
						cause_of(req.access_kind), 1'b1);
				end else begin
					state_next.busy      = 1'b1;
					state_next.level     = TOP_LEVEL;
					state_next.table_ppn = cfg.root_ppn;
					state_next.vaddr     = req.virt_addr;
					state_next.kind      = req.access_kind;
					state_next.priv      = req.privilege;
					res0 = make_rsp(RES_READ, pte_addr(cfg.root_ppn, req.virt_addr, TOP_LEVEL),
						64'd0, CAUSE_FETCH, 1'b1);
				end
			end
		end else if (state.busy) begin
			res_n = 2'd1;
			if (req.read_error || !pte[PTE_V] || (pte[PTE_W] && !pte[PTE_R])) begin
				state_next.busy = 1'b0;
				res0 = fault_rsp;
			end else if (!pte[PTE_R] && !pte[PTE_X]) begin
				if (state.level == 2'd0) begin
					state_next.busy = 1'b0;
					res0 = fault_rsp;
				end else begin
					state_next.level     = state.level - 2'd1;
					state_next.table_ppn = pte_ppn;
					res0 = make_rsp(RES_READ, pte_addr(pte_ppn, state.vaddr, state.level - 2'd1),
						64'd0, CAUSE_FETCH, 1'b1);
				end
			end else if (!(priv_ok && kind_ok) || (pte_ppn & low_mask) != '0) begin
				state_next.busy = 1'b0;
				res0 = fault_rsp;
			end else begin
				state_next.busy = 1'b0;
				if (updated != pte) begin
					res_n = 2'd2;
					res0 = make_rsp(RES_WRITE, pte_addr(state.table_ppn, state.vaddr, state.level),
						updated, CAUSE_FETCH, 1'b0);
					res1 = make_rsp(RES_DONE, phys_addr, 64'd0, CAUSE_FETCH, 1'b1);
				end else begin
					res0 = make_rsp(RES_DONE, phys_addr, 64'd0, CAUSE_FETCH, 1'b1);
				end
			end
		end
	end

endmodule

// File: sv/sv39_ptw_outq.sv
// Result queue that takes up to two results a cycle and hands out one while rsp_stall is low.
module sv39_ptw_outq #(
	parameter int unsigned DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [1:0]         push_n,
	input  sv39_ptw_pkg::rsp_t push0,
	input  sv39_ptw_pkg::rsp_t push1,
	output logic               has_room,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output sv39_ptw_pkg::rsp_t rsp
);
	import sv39_ptw_pkg::*;

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	rsp_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          pop;

	assign rsp_valid = count_q != '0;
	assign rsp       = mem_q[rd_ptr_q];
	assign pop       = rsp_valid && !rsp_stall;
	assign has_room  = count_q <= CW'(DEPTH - 2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PW'(push_n);
			rd_ptr_q <= rd_ptr_q + PW'(pop);
			count_q  <= count_q + CW'(push_n) - CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_n != 2'd0)
			mem_q[wr_ptr_q] <= push0;
		if (push_n == 2'd2)
			mem_q[wr_ptr_q + PW'(1)] <= push1;
	end

endmodule

// File: sv/sv39_page_table_walker_top.sv
// Top level of the Sv39 page table walker: input stage, walk state, configuration and result queue.
//
// Channel  Direction  Handshake              Content
// req      in         req_valid / req_stall  translate request or PTE read response
// rsp      out        rsp_valid / rsp_stall  done, fault, PTE read or PTE write request
// cfg      in         cfg_valid / cfg_ready  register index and write data
//
// A request is taken per cycle unless stalled; it waits in the input stage until the queue has room.
// The queue hands out one result per cycle while rsp_stall is low, so paired results leave in turn.
// req_stall rises while the input stage holds a request and the queue has fewer than two free places.
// Reset clears the walk state, the configuration and the queue; no clearing pass is needed.
module sv39_page_table_walker_top #(
	parameter int unsigned OUTQ_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  sv39_ptw_pkg::req_t req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output sv39_ptw_pkg::rsp_t rsp,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [63:0]        cfg_data
);
	import sv39_ptw_pkg::*;

	req_t        req_s1;
	logic        valid_s1;
	walk_state_t state_q;
	walk_state_t state_next;
	cfg_t        cfg_q;
	logic [1:0]  step_n;
	logic [1:0]  push_n;
	rsp_t        step_res0;
	rsp_t        step_res1;
	logic        has_room;
	logic        advance;
	logic        accept;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && has_room;
	assign req_stall = valid_s1 && !has_room;
	assign accept    = req_valid && !req_stall;
	assign push_n    = advance ? step_n : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			req_s1 <= req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MODE: cfg_q.mode     <= cfg_data[3:0];
				CFG_ROOT: cfg_q.root_ppn <= cfg_data[PPN_W-1:0];
				CFG_SUM:  cfg_q.sum      <= cfg_data[0];
				CFG_MXR:  cfg_q.mxr      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	sv39_ptw_step u_step (
		.req        (req_s1),
		.state      (state_q),
		.cfg        (cfg_q),
		.res_n      (step_n),
		.res0       (step_res0),
		.res1       (step_res1),
		.state_next (state_next)
	);

	sv39_ptw_outq #(
		.DEPTH (OUTQ_DEPTH)
	) u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.push0     (step_res0),
		.push1     (step_res1),
		.has_room  (has_room),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	a_walk_starts_with_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q.busy) |-> $past(advance && step_res0.result_kind == RES_READ))
		else $error("walk started without a PTE read request");

	a_pair_is_write_then_done: assert property (@(posedge clk) disable iff (!arst_n)
		advance && step_n == 2'd2 |-> step_res0.result_kind == RES_WRITE
			&& step_res1.result_kind == RES_DONE && step_res1.last_of_run)
		else $error("two results are not a write-back followed by completion");

	a_only_write_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.last_of_run |-> rsp.result_kind == RES_WRITE)
		else $error("non-final result that is not a write-back");

	a_walk_ends_on_final: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(state_q.busy) |-> $past(advance && step_res0.result_kind != RES_READ))
		else $error("walk ended on a read request");

	a_no_result_idle_response: assert property (@(posedge clk) disable iff (!arst_n)
		advance && req_s1.func == FUNC_RESPONSE && !state_q.busy |-> step_n == 2'd0)
		else $error("response while idle produced a result");

endmodule

// File: tb/sv39_walk_checker.sv
// Watches the walker's channels, predicts each result from accepted requests and compares them.
module sv39_walk_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_stall,
	input  sv39_ptw_pkg::req_t req,
	input  logic               rsp_valid,
	input  logic               rsp_stall,
	input  sv39_ptw_pkg::rsp_t rsp,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [63:0]        cfg_data,
	output int                 mismatches,
	output int                 outstanding
);
	import sv39_ptw_pkg::*;

	cfg_t        regs;
	walk_state_t walk;
	rsp_t        predicted_rsps [$];
	int          fail_total = 0;
	int          queued = 0;

	assign mismatches  = fail_total;
	assign outstanding = queued;

	task automatic report_mismatch(input string what);
		fail_total++;
		if (fail_total <= 100) begin
			$display("%0t: %s", $time, what);
		end
	endtask

	task automatic push_result(input logic [1:0] kind, input logic [63:0] addr,
			input logic [63:0] wdata, input logic [1:0] cause, input logic last);
		rsp_t r;
		r.result_kind = kind;
		r.address     = addr;
		r.write_data  = wdata;
		r.fault_cause = cause;
		r.last_of_run = last;
		predicted_rsps.push_back(r);
	endtask

	task automatic end_in_fault(input logic [63:0] va, input logic [1:0] kind);
		logic [1:0] cause;
		if (kind == ACC_FETCH) begin
			cause = CAUSE_FETCH;
		end else if (kind == ACC_STORE) begin
			cause = CAUSE_STORE;
		end else begin
			cause = CAUSE_LOAD;
		end
		walk.busy = 1'b0;
		push_result(RES_FAULT, va, '0, cause, 1'b1);
	endtask

	function automatic logic [63:0] entry_addr();
		logic [8:0] idx;
		idx = 9'(walk.vaddr >> (PAGE_OFS_W + VPN_W * walk.level));
		return {8'h00, walk.table_ppn, idx, 3'b000};
	endfunction

	task automatic predict_walk_step(input req_t r);
		logic [63:0] pte;
		logic [63:0] updated;
		logic [63:0] pa;
		logic [43:0] ppn;
		logic [43:0] low;
		logic        ok;
		if (r.func == FUNC_TRANSLATE) begin
			if (walk.busy) begin
				return;
			end
			if (r.privilege == PRIV_M_MODE || regs.mode == MODE_BARE) begin
				push_result(RES_DONE, r.virt_addr, '0, '0, 1'b1);
				return;
			end
			if (r.virt_addr[63:38] != '0 && r.virt_addr[63:38] != '1) begin
				end_in_fault(r.virt_addr, r.access_kind);
				return;
			end
			walk.busy      = 1'b1;
			walk.level     = TOP_LEVEL;
			walk.table_ppn = regs.root_ppn;
			walk.vaddr     = r.virt_addr;
			walk.kind      = r.access_kind;
			walk.priv      = r.privilege;
			push_result(RES_READ, entry_addr(), '0, '0, 1'b1);
			return;
		end
		if (!walk.busy) begin
			return;
		end
		pte = r.read_data;
		if (r.read_error || !pte[PTE_V] || (pte[PTE_W] && !pte[PTE_R])) begin
			end_in_fault(walk.vaddr, walk.kind);
			return;
		end
		ppn = pte[53:10];
		if (!pte[PTE_R] && !pte[PTE_X]) begin
			if (walk.level == 2'd0) begin
				end_in_fault(walk.vaddr, walk.kind);
				return;
			end
			walk.level     = walk.level - 2'd1;
			walk.table_ppn = ppn;
			push_result(RES_READ, entry_addr(), '0, '0, 1'b1);
			return;
		end
		if (walk.priv == PRIV_U_MODE) begin
			ok = pte[PTE_U];
		end else begin
			ok = !(pte[PTE_U] && (walk.kind == ACC_FETCH || !regs.sum));
		end
		case (walk.kind)
			ACC_FETCH: ok = ok && pte[PTE_X];
			ACC_LOAD:  ok = ok && (pte[PTE_R] || (regs.mxr && pte[PTE_X]));
			ACC_STORE: ok = ok && pte[PTE_W];
			default:   ok = 1'b0;
		endcase
		low = (44'd1 << (VPN_W * walk.level)) - 44'd1;
		if (!ok || (ppn & low) != '0) begin
			end_in_fault(walk.vaddr, walk.kind);
			return;
		end
		ppn = ppn | (44'(walk.vaddr >> PAGE_OFS_W) & low);
		pa = {8'h00, ppn, walk.vaddr[11:0]};
		updated = pte | (64'd1 << PTE_A);
		if (walk.kind == ACC_STORE) begin
			updated = updated | (64'd1 << PTE_D);
		end
		walk.busy = 1'b0;
		if (updated != pte) begin
			push_result(RES_WRITE, entry_addr(), updated, '0, 1'b0);
		end
		push_result(RES_DONE, pa, '0, '0, 1'b1);
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			regs = '0;
			walk = '0;
			predicted_rsps.delete();
			queued <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (predicted_rsps.size() == 0) begin
					report_mismatch($sformatf("unexpected result: kind %0d address %h",
						rsp.result_kind, rsp.address));
				end else begin
					want = predicted_rsps.pop_front();
					if (rsp.result_kind !== want.result_kind || rsp.address !== want.address ||
							rsp.write_data !== want.write_data ||
							rsp.fault_cause !== want.fault_cause ||
							rsp.last_of_run !== want.last_of_run) begin
						report_mismatch($sformatf(
							"got/expected kind %0d/%0d addr %h/%h data %h/%h cause %0d/%0d last %b/%b",
							rsp.result_kind, want.result_kind, rsp.address, want.address,
							rsp.write_data, want.write_data, rsp.fault_cause, want.fault_cause,
							rsp.last_of_run, want.last_of_run));
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_MODE: regs.mode     = cfg_data[3:0];
					CFG_ROOT: regs.root_ppn = cfg_data[PPN_W-1:0];
					CFG_SUM:  regs.sum      = cfg_data[0];
					CFG_MXR:  regs.mxr      = cfg_data[0];
					default:  ;
				endcase
			end
			if (req_valid && !req_stall) begin
				predict_walk_step(req);
			end
			queued <= predicted_rsps.size();
		end
	end

endmodule

// File: tb/tb_sv39_page_table_walker_top.sv
// Testbench top for the Sv39 page table walker: drives requests, configuration and stalls.
module tb_sv39_page_table_walker_top;
	import sv39_ptw_pkg::*;

	localparam logic [1:0] ACC_UNDEFINED   = 2'd3;
	localparam logic [1:0] PRIV_SUPERVISOR = 2'd1;
	localparam logic [1:0] PRIV_RESERVED   = 2'd2;
	localparam logic [3:0] MODE_SV39       = 4'd8;
	localparam logic [3:0] MODE_TOP        = 4'd15;
	localparam logic [7:0] FLAG_V = 8'(1 << PTE_V);
	localparam logic [7:0] FLAG_R = 8'(1 << PTE_R);
	localparam logic [7:0] FLAG_W = 8'(1 << PTE_W);
	localparam logic [7:0] FLAG_X = 8'(1 << PTE_X);
	localparam logic [7:0] FLAG_U = 8'(1 << PTE_U);
	localparam logic [7:0] FLAG_A = 8'(1 << PTE_A);

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	req_t        req = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	rsp_t        rsp;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = CFG_MODE;
	logic [63:0] cfg_data = '0;
	int          mismatches;
	int          outstanding;
	bit          calm = 1'b0;
	int          holdoff_asked = 0;
	int          items_sent = 0;

	sv39_page_table_walker_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	sv39_walk_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2000000;
		$display("[sv39_page_table_walker_top] ERROR");
		$finish;
	end

	// The receiver stalls at random, and on request holds off for a long stretch.
	initial begin
		int served;
		int left;
		served = 0;
		left = 0;
		forever begin
			@(posedge clk);
			if (left == 0 && served != holdoff_asked) begin
				served = holdoff_asked;
				left = 120;
			end
			if (left > 0) begin
				rsp_stall <= 1'b1;
				left--;
			end else begin
				rsp_stall <= !calm && ($urandom_range(0, 99) < 32);
			end
		end
	end

	function automatic req_t random_item();
		req_t r;
		r.func        = 1'($urandom);
		r.virt_addr   = {$urandom, $urandom};
		r.access_kind = 2'($urandom);
		r.privilege   = 2'($urandom);
		r.read_data   = {$urandom, $urandom};
		r.read_error  = 1'($urandom);
		return r;
	endfunction

	function automatic req_t translate_item(input logic [63:0] va, input logic [1:0] kind,
			input logic [1:0] priv);
		req_t r;
		r = random_item();
		r.func        = FUNC_TRANSLATE;
		r.virt_addr   = va;
		r.access_kind = kind;
		r.privilege   = priv;
		return r;
	endfunction

	function automatic req_t pte_response(input logic [63:0] pte);
		req_t r;
		r = random_item();
		r.func       = FUNC_RESPONSE;
		r.read_data  = pte;
		r.read_error = 1'b0;
		return r;
	endfunction

	function automatic logic [63:0] make_pte(input logic [43:0] ppn, input logic [7:0] flags);
		return {10'h000, ppn, 2'b00, flags};
	endfunction

	// An invalid entry ends any walk in progress and is ignored when the walker is idle.
	function automatic req_t resync_item();
		req_t r;
		r = pte_response({$urandom, $urandom});
		r.read_data[PTE_V] = 1'b0;
		return r;
	endfunction

	task automatic send(input req_t item);
		if (!calm && $urandom_range(0, 99) < 32) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		items_sent++;
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(input logic [3:0] mode, input logic [43:0] root, input logic sum,
			input logic mxr);
		logic [1:0]  regs [4];
		logic [63:0] values [4];
		regs[0] = CFG_MODE;
		regs[1] = CFG_ROOT;
		regs[2] = CFG_SUM;
		regs[3] = CFG_MXR;
		values[0] = {60'({$urandom, $urandom}), mode};
		values[1] = {20'($urandom), root};
		values[2] = {63'({$urandom, $urandom}), sum};
		values[3] = {63'({$urandom, $urandom}), mxr};
		for (int i = 0; i < 4; i++) begin
			cfg_index <= regs[i];
			cfg_data  <= values[i];
			cfg_valid <= 1'b1;
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic walk_sequence(input bit broken);
		req_t        item;
		logic [63:0] va;
		logic [63:0] pte;
		logic [1:0]  priv;
		logic        err;
		int          leaf_level;
		int          break_level;
		int          p;
		va = {$urandom, $urandom};
		if ($urandom_range(0, 19) != 0) begin
			va[63:38] = {26{va[38]}};
		end
		p = $urandom_range(0, 19);
		if (p == 0) begin
			priv = PRIV_M_MODE;
		end else if (p == 1) begin
			priv = PRIV_RESERVED;
		end else if (p < 11) begin
			priv = PRIV_U_MODE;
		end else begin
			priv = PRIV_SUPERVISOR;
		end
		send(translate_item(va, ($urandom_range(0, 15) == 0) ? ACC_UNDEFINED :
			2'($urandom_range(0, 2)), priv));
		leaf_level = $urandom_range(0, 2);
		break_level = $urandom_range(leaf_level, int'(TOP_LEVEL));
		for (int lvl = int'(TOP_LEVEL); lvl >= leaf_level; lvl--) begin
			pte = {$urandom, $urandom};
			pte[PTE_V] = 1'b1;
			err = 1'b0;
			if (lvl > leaf_level) begin
				pte[PTE_R] = 1'b0;
				pte[PTE_W] = 1'b0;
				pte[PTE_X] = 1'b0;
			end else begin
				pte[PTE_R] = $urandom_range(0, 9) < 7;
				pte[PTE_X] = $urandom_range(0, 9) < 6;
				if (!pte[PTE_R] && !pte[PTE_X]) begin
					pte[PTE_R] = 1'b1;
				end
				if (pte[PTE_W] && !pte[PTE_R] && $urandom_range(0, 7) != 0) begin
					pte[PTE_R] = 1'b1;
				end
				pte[PTE_U] = (priv == PRIV_U_MODE) ? ($urandom_range(0, 9) < 8) :
					($urandom_range(0, 9) < 3);
				if ($urandom_range(0, 7) != 0) begin
					pte = pte & ~(((64'd1 << (VPN_W * lvl)) - 64'd1) << 10);
				end
			end
			if (broken && lvl == break_level) begin
				case ($urandom_range(0, 2))
					0: err = 1'b1;
					1: pte[PTE_V] = 1'b0;
					default: begin
						pte[PTE_R] = 1'b0;
						pte[PTE_W] = 1'b1;
					end
				endcase
			end
			item = pte_response(pte);
			item.read_error = err;
			send(item);
			if (broken && lvl == break_level) begin
				break;
			end
		end
	endtask

	task automatic run_phase(input logic [3:0] mode, input logic [43:0] root, input logic sum,
			input logic mxr, input int count, input bit quiet_sides, input bit squeeze);
		int stop_at;
		int pick;
		send(resync_item());
		drain();
		configure(mode, root, sum, mxr);
		calm = quiet_sides;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			if (squeeze && holdoff_asked == 0 && items_sent > stop_at - count / 2) begin
				holdoff_asked++;
			end
			pick = $urandom_range(0, 99);
			if (pick < 75) begin
				walk_sequence(1'b0);
			end else if (pick < 88) begin
				walk_sequence(1'b1);
			end else begin
				send(random_item());
				send(resync_item());
			end
		end
		calm = 1'b0;
	endtask

	initial begin
		req_t item;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(translate_item('1, ACC_STORE, PRIV_U_MODE));
		send(pte_response('1));
		drain();
		configure(MODE_SV39, 44'h0AB_CDEF_1234, 1'b0, 1'b0);

		send(translate_item(64'h8000_0000_0000_1234, ACC_LOAD, PRIV_M_MODE));
		send(translate_item(64'h0000_0040_0000_0000, ACC_FETCH, PRIV_SUPERVISOR));
		send(translate_item(64'hFFFF_FF80_0000_0000, ACC_UNDEFINED, PRIV_U_MODE));

		// Privilege two in the upper half, store to a clean small page.
		send(translate_item('1, ACC_STORE, PRIV_RESERVED));
		send(pte_response(make_pte('1, FLAG_V)));
		send(pte_response(make_pte('0, FLAG_V)));
		send(pte_response(make_pte('1, FLAG_V | FLAG_R | FLAG_W)));

		send(translate_item('0, ACC_LOAD, PRIV_U_MODE));
		item = pte_response(make_pte('1, FLAG_V | FLAG_R | FLAG_U | FLAG_A));
		item.read_error = 1'b1;
		send(item);

		send(translate_item(64'h0000_0012_3456_7ABC, ACC_LOAD, PRIV_SUPERVISOR));
		send(pte_response(make_pte(44'h123, FLAG_R | FLAG_W | FLAG_X)));

		send(translate_item(64'h0000_0022_2222_2000, ACC_STORE, PRIV_SUPERVISOR));
		send(pte_response(make_pte(44'h55, FLAG_V | FLAG_W)));

		// Pointers at every level leave no leaf.
		send(translate_item(64'h0000_003F_FFFF_F000, ACC_FETCH, PRIV_U_MODE));
		repeat (3) send(pte_response(make_pte(44'h1000, FLAG_V)));

		send(translate_item(64'h0000_0000_4000_0000, ACC_LOAD, PRIV_SUPERVISOR));
		send(pte_response(make_pte(44'h4_0001, FLAG_V | FLAG_R | FLAG_A)));

		// Aligned gigapage with the accessed bit set and the top ten bits of the entry set.
		send(translate_item(64'h0000_0001_2345_6789, ACC_LOAD, PRIV_U_MODE));
		send(pte_response(make_pte(44'h4_0000, FLAG_V | FLAG_R | FLAG_U | FLAG_A) |
			{10'h3FF, 54'h0}));

		// A second translate while the walk is in progress is dropped.
		send(translate_item(64'h0000_0000_0000_0ABC, ACC_LOAD, PRIV_SUPERVISOR));
		send(translate_item(64'h0000_0000_8000_0000, ACC_STORE, PRIV_M_MODE));
		send(pte_response(make_pte(44'h8_0000, FLAG_V | FLAG_X | FLAG_A)));

		run_phase(MODE_SV39, '0, 1'b0, 1'b0, 70, 1'b0, 1'b0);
		run_phase(MODE_TOP, '1, 1'b1, 1'b1, 70, 1'b0, 1'b0);
		run_phase(MODE_BARE, 44'($urandom), 1'b0, 1'b1, 30, 1'b0, 1'b0);
		run_phase(4'($urandom_range(1, 15)), {12'($urandom), 32'($urandom)}, 1'($urandom),
			1'($urandom), 80, 1'b1, 1'b0);
		run_phase(MODE_SV39, {12'($urandom), 32'($urandom)}, 1'b1, 1'b0, 80, 1'b0, 1'b1);
		run_phase(MODE_SV39, {12'($urandom), 32'($urandom)}, 1'b0, 1'b1, 80, 1'b0, 1'b0);

		drain();
		if (mismatches == 0 && outstanding == 0) begin
			$display("[sv39_page_table_walker_top] OK");
		end else begin
			$display("[sv39_page_table_walker_top] ERROR");
		end
		$finish;
	end

endmodule

// File: sim.f
sv/sv39_ptw_pkg.sv
sv/sv39_ptw_step.sv
sv/sv39_ptw_outq.sv
sv/sv39_page_table_walker_top.sv
tb/sv39_walk_checker.sv
tb/tb_sv39_page_table_walker_top.sv
